// ----- sv/scr_pkg.sv -----
// Shared types and constants for the scanline coverage span resolver.
package scr_pkg;

  localparam int SUB_ROWS = 4;
  localparam int SUB_COLS = 4;
  localparam int MASK_W   = SUB_ROWS * SUB_COLS;
  localparam int COV_W    = 6;
  localparam int MAX_RUNS = 3;
  localparam int CNT_W    = 2;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 2;

  localparam int W_EDGE   = 1;
  localparam int W_MID    = 2;
  localparam int SPAN_W   = 8;
  localparam int COV_FULL = 32;

  localparam logic [IDX_W-1:0] REG_QUALITY  = 2'd0;
  localparam logic [IDX_W-1:0] REG_CLIP_MIN = 2'd1;
  localparam logic [IDX_W-1:0] REG_CLIP_MAX = 2'd2;

  typedef struct packed {
    logic [SUB_ROWS-1:0] parity;
    logic [COV_W-1:0]    cell_cov;
    logic [COV_W-1:0]    span_cov;
  } cov_res_t;

endpackage

// ----- sv/scr_cell_cov.sv -----
// Cell coverage from sub-row parity and toggle mask, plus the updated parity.
module scr_cell_cov (
  input  logic                          quality_mode,
  input  logic [scr_pkg::SUB_ROWS-1:0]  parity,
  input  logic [scr_pkg::MASK_W-1:0]    mask,
  output scr_pkg::cov_res_t             res
);
  import scr_pkg::*;

  logic [3:0]          row_sum [SUB_ROWS];
  logic [SUB_ROWS-1:0] par_q;

  // per sub-row: weights 1,2,2,2,1 across the subsample columns
  always_comb begin
    logic d;
    for (int r = 0; r < SUB_ROWS; r++) begin
      d = parity[r];
      row_sum[r] = d ? 4'(W_EDGE) : 4'd0;
      for (int c = 0; c < SUB_COLS; c++) begin
        d = d ^ mask[SUB_COLS*r + c];
        if (d) begin
          row_sum[r] = row_sum[r] + ((c == SUB_COLS-1) ? 4'(W_EDGE) : 4'(W_MID));
        end
      end
      par_q[r] = d;
    end
  end

  always_comb begin
    logic [COV_W-1:0] acc;
    logic [2:0]       rows_in;
    acc     = '0;
    rows_in = '0;
    for (int r = 0; r < SUB_ROWS; r++) begin
      acc     = acc + COV_W'(row_sum[r]);
      rows_in = rows_in + 3'(par_q[r]);
    end
    if (quality_mode) begin
      res.parity   = par_q;
      res.cell_cov = acc;
      res.span_cov = COV_W'(rows_in) * COV_W'(SPAN_W);
    end else begin
      res.parity   = parity ^ {{(SUB_ROWS-1){1'b0}}, mask[0]};
      res.cell_cov = COV_W'(parity[0]);
      res.span_cov = COV_W'(parity[0] ^ mask[0]);
    end
  end

endmodule

// ----- sv/scr_out_buf.sv -----
// Result buffer: packs up to three runs of one transaction and drains one per cycle while run_ready is high.
module scr_out_buf #(
  parameter int X_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  logic [scr_pkg::MAX_RUNS-1:0]      cand_valid,
  input  logic signed [X_BITS-1:0]          cand_start [scr_pkg::MAX_RUNS],
  input  logic signed [X_BITS-1:0]          cand_end   [scr_pkg::MAX_RUNS],
  input  logic [scr_pkg::COV_W-1:0]         cand_cov   [scr_pkg::MAX_RUNS],
  output logic                              can_load,
  output logic                              run_valid,
  input  logic                              run_ready,
  output logic signed [X_BITS-1:0]          run_start,
  output logic signed [X_BITS-1:0]          run_end,
  output logic [scr_pkg::COV_W-1:0]         coverage,
  output logic                              last
);
  import scr_pkg::*;

  logic signed [X_BITS-1:0] buf_start [MAX_RUNS];
  logic signed [X_BITS-1:0] buf_end   [MAX_RUNS];
  logic [COV_W-1:0]         buf_cov   [MAX_RUNS];
  logic [MAX_RUNS-1:0]      buf_last;
  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         load_cnt;
  logic [CNT_W-1:0]         sel [MAX_RUNS];
  logic                     pop;

  always_comb begin
    sel[0] = cand_valid[0] ? CNT_W'(0) : (cand_valid[1] ? CNT_W'(1) : CNT_W'(2));
    sel[1] = (cand_valid[0] && cand_valid[1]) ? CNT_W'(1) : CNT_W'(2);
    sel[2] = CNT_W'(2);
    load_cnt = CNT_W'(cand_valid[0]) + CNT_W'(cand_valid[1]) + CNT_W'(cand_valid[2]);
  end

  assign run_valid = (cnt != '0);
  assign pop       = run_valid && run_ready;
  assign can_load  = (cnt == '0) || ((cnt == CNT_W'(1)) && run_ready);
  assign run_start = buf_start[0];
  assign run_end   = buf_end[0];
  assign coverage  = buf_cov[0];
  assign last      = buf_last[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= load_cnt;
    end else if (pop) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < MAX_RUNS; k++) begin
        buf_start[k] <= cand_start[sel[k]];
        buf_end[k]   <= cand_end[sel[k]];
        buf_cov[k]   <= cand_cov[sel[k]];
        buf_last[k]  <= (CNT_W'(k + 1) == load_cnt);
      end
    end else if (pop) begin
      for (int k = 0; k < MAX_RUNS-1; k++) begin
        buf_start[k] <= buf_start[k+1];
        buf_end[k]   <= buf_end[k+1];
        buf_cov[k]   <= buf_cov[k+1];
        buf_last[k]  <= buf_last[k+1];
      end
    end
  end

endmodule

// ----- sv/scanline_coverage_span_resolver.sv -----
// Top level: scanline coverage span resolver with APB register port.
// The first run of a transaction is on the output in the cycle after it is loaded into the result buffer.
// Throughput: one cell per cycle while each cell yields at most one run and run_ready is high; a
// cell yielding more runs holds the single output port, and so the input, until its runs drain to the last.
// Reset (rst, synchronous): registers to quality 1, clip window [0, 1024),
// row state cleared, no run pending; no clearing pass.
module scanline_coverage_span_resolver #(
  parameter int X_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cell_valid,
  output logic                          cell_ready,
  input  logic signed [X_BITS-1:0]      cell_x,
  input  logic [scr_pkg::MASK_W-1:0]    cell_mask,
  input  logic                          row_last,
  output logic                          run_valid,
  input  logic                          run_ready,
  output logic signed [X_BITS-1:0]      run_start,
  output logic signed [X_BITS-1:0]      run_end,
  output logic [scr_pkg::COV_W-1:0]     coverage,
  output logic                          last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [scr_pkg::ADDR_W-1:0]    paddr,
  input  logic [scr_pkg::DATA_W-1:0]    pwdata,
  output logic [scr_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import scr_pkg::*;

  localparam int XW = X_BITS + 1;

  // configuration
  logic                     quality_mode;
  logic signed [X_BITS-1:0] clip_min_x;
  logic signed [X_BITS-1:0] clip_max_x;
  logic [IDX_W-1:0]         reg_idx;

  // input register
  logic                     s1_valid;
  logic signed [X_BITS-1:0] s1_x;
  logic [MASK_W-1:0]        s1_mask;
  logic                     s1_last;
  logic                     s1_fire;

  // row state
  logic [SUB_ROWS-1:0]      row_parity;
  logic signed [X_BITS-1:0] pending_x;
  logic [COV_W-1:0]         pending_cell_cover;
  logic [COV_W-1:0]         pending_span_cover;
  logic                     have_pending;
  logic                     row_stopped;

  cov_res_t                 cov_res;
  logic                     can_load;
  logic                     stop;
  logic                     emit_pend;
  logic signed [XW-1:0]     x_w, pend_w, cmin_w, cmax_w, span_s, span_b, span_e;
  logic [MAX_RUNS-1:0]      cand_valid;
  logic signed [X_BITS-1:0] cand_start [MAX_RUNS];
  logic signed [X_BITS-1:0] cand_end   [MAX_RUNS];
  logic [COV_W-1:0]         cand_cov   [MAX_RUNS];

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      quality_mode <= 1'b1;
      clip_min_x   <= '0;
      clip_max_x   <= X_BITS'(1024);
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_QUALITY:  quality_mode <= pwdata[0];
        REG_CLIP_MIN: clip_min_x   <= pwdata[X_BITS-1:0];
        REG_CLIP_MAX: clip_max_x   <= pwdata[X_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_QUALITY:  prdata = {{(DATA_W-1){1'b0}}, quality_mode};
      REG_CLIP_MIN: prdata = DATA_W'(clip_min_x);
      REG_CLIP_MAX: prdata = DATA_W'(clip_max_x);
      default:      prdata = '0;
    endcase
  end

  assign s1_fire    = s1_valid && can_load;
  assign cell_ready = !s1_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cell_ready) begin
      s1_valid <= cell_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_valid && cell_ready) begin
      s1_x    <= cell_x;
      s1_mask <= cell_mask;
      s1_last <= row_last;
    end
  end

  scr_cell_cov u_cell_cov (
    .quality_mode (quality_mode),
    .parity       (row_parity),
    .mask         (s1_mask),
    .res          (cov_res)
  );

  assign x_w    = XW'(s1_x);
  assign pend_w = XW'(pending_x);
  assign cmin_w = XW'(clip_min_x);
  assign cmax_w = XW'(clip_max_x);

  assign stop      = (x_w >= cmax_w);
  assign emit_pend = !row_stopped && have_pending;

  // span from the held cell up to this cell, clipped
  assign span_b = (pend_w >= cmin_w) ? pend_w + XW'(1) : pend_w;
  assign span_s = (span_b < cmin_w) ? cmin_w : span_b;
  assign span_e = (x_w > cmax_w) ? cmax_w : x_w;

  always_comb begin
    cand_valid[0] = emit_pend && (pend_w >= cmin_w) && (pend_w < cmax_w)
                    && (pending_cell_cover != '0);
    cand_start[0] = pending_x;
    cand_end[0]   = pending_x + X_BITS'(1);
    cand_cov[0]   = pending_cell_cover;

    cand_valid[1] = emit_pend && (x_w > span_b) && (x_w > cmin_w)
                    && (span_s < span_e) && (pending_span_cover != '0);
    cand_start[1] = span_s[X_BITS-1:0];
    cand_end[1]   = span_e[X_BITS-1:0];
    cand_cov[1]   = pending_span_cover;

    cand_valid[2] = emit_pend && !stop && s1_last && (x_w >= cmin_w)
                    && (cov_res.cell_cov != '0);
    cand_start[2] = s1_x;
    cand_end[2]   = s1_x + X_BITS'(1);
    cand_cov[2]   = cov_res.cell_cov;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_parity         <= '0;
      pending_x          <= '0;
      pending_cell_cover <= '0;
      pending_span_cover <= '0;
      have_pending       <= 1'b0;
      row_stopped        <= 1'b0;
    end else if (s1_fire) begin
      if (s1_last) begin
        row_parity         <= '0;
        pending_x          <= '0;
        pending_cell_cover <= '0;
        pending_span_cover <= '0;
        have_pending       <= 1'b0;
        row_stopped        <= 1'b0;
      end else if (!row_stopped) begin
        if (stop) begin
          have_pending <= 1'b0;
          row_stopped  <= 1'b1;
        end else begin
          row_parity         <= cov_res.parity;
          pending_x          <= s1_x;
          pending_cell_cover <= cov_res.cell_cov;
          pending_span_cover <= cov_res.span_cov;
          have_pending       <= 1'b1;
        end
      end
    end
  end

  scr_out_buf #(
    .X_BITS (X_BITS)
  ) u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .load       (s1_fire),
    .cand_valid (cand_valid),
    .cand_start (cand_start),
    .cand_end   (cand_end),
    .cand_cov   (cand_cov),
    .can_load   (can_load),
    .run_valid  (run_valid),
    .run_ready  (run_ready),
    .run_start  (run_start),
    .run_end    (run_end),
    .coverage   (coverage),
    .last       (last)
  );

endmodule

// ----- sv/scr_checker.sv -----
// Port-level assertions for the span resolver, bound to the top level.
module scr_checker #(
  parameter int X_BITS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          run_valid,
  input logic                          run_ready,
  input logic signed [X_BITS-1:0]      run_start,
  input logic signed [X_BITS-1:0]      run_end,
  input logic [scr_pkg::COV_W-1:0]     coverage,
  input logic                          last
);
  import scr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    run_valid && !run_ready |=> run_valid && $stable(run_start) && $stable(run_end)
      && $stable(coverage) && $stable(last))
    else $error("run transaction changed while stalled");

  a_run_order: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> run_start < run_end)
    else $error("empty run emitted");

  a_cov_range: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> coverage != '0 && coverage <= COV_W'(COV_FULL))
    else $error("run coverage out of range");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !run_valid)
    else $error("run valid right after reset");

endmodule

bind scanline_coverage_span_resolver scr_checker #(
  .X_BITS (X_BITS)
) u_scr_checker (
  .clk       (clk),
  .rst       (rst),
  .run_valid (run_valid),
  .run_ready (run_ready),
  .run_start (run_start),
  .run_end   (run_end),
  .coverage  (coverage),
  .last      (last)
);

// ----- tb/sv/scanline_coverage_span_resolver_test.sv -----
// Self-checking testbench for the scanline coverage span resolver: directed table plus random rows.
module scanline_coverage_span_resolver_test;
  timeunit 1ns;
  timeprecision 1ps;
  import scr_pkg::*;

  localparam int XW = 16;
  localparam int PREDICT = -1;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_WAIT = 12;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic signed [XW-1:0] start_x;
    logic signed [XW-1:0] stop_x;
    logic [COV_W-1:0]     cov;
    logic                 is_last;
  } run_t;

  typedef enum bit {STEP_CELL, STEP_REG} step_kind_t;

  // cell rows: a = x, b = mask; register rows: a = index, b = value
  typedef struct packed {
    step_kind_t kind;
    int         a;
    int         b;
    bit         rl;
    int         n_fix;
    int         fix_s;
    int         fix_e;
    int         fix_c;
  } plan_t;

  localparam int PLAN_N = 23;
  localparam plan_t PLAN [PLAN_N] = '{
    '{STEP_CELL, 10,     'h1111, 1'b0, 0,       0,   0,   0},
    '{STEP_CELL, 20,     'h1111, 1'b1, PREDICT, 0,   0,   0},
    '{STEP_CELL, 5,      'hFFFF, 1'b1, 0,       0,   0,   0},
    '{STEP_CELL, -32768, 'h0001, 1'b0, 0,       0,   0,   0},
    '{STEP_CELL, 3,      'h0000, 1'b0, 1,       0,   3,   8},
    '{STEP_CELL, 3,      'h8888, 1'b0, PREDICT, 0,   0,   0},
    '{STEP_CELL, 32767,  'hFFFF, 1'b0, PREDICT, 0,   0,   0},
    '{STEP_CELL, 40,     'h1234, 1'b0, 0,       0,   0,   0},
    '{STEP_CELL, 50,     'h0000, 1'b1, 0,       0,   0,   0},
    '{STEP_REG,  REG_QUALITY, 0, 1'b0, 0,       0,   0,   0},
    '{STEP_CELL, 100,    'h0001, 1'b0, 0,       0,   0,   0},
    '{STEP_CELL, 200,    'hFFFE, 1'b0, 1,       101, 200, 1},
    '{STEP_CELL, 300,    'h0001, 1'b1, PREDICT, 0,   0,   0},
    '{STEP_CELL, 10,     'h0001, 1'b0, 0,       0,   0,   0},
    '{STEP_REG,  REG_QUALITY, 1, 1'b0, 0,       0,   0,   0},
    '{STEP_CELL, 20,     'h0000, 1'b1, PREDICT, 0,   0,   0},
    '{STEP_REG,  REG_CLIP_MIN, -32768, 1'b0, 0, 0,   0,   0},
    '{STEP_REG,  REG_CLIP_MAX, 32767,  1'b0, 0, 0,   0,   0},
    '{STEP_CELL, -32768, 'hFFFF, 1'b0, 0,       0,   0,   0},
    '{STEP_CELL, 32766,  'hF000, 1'b1, PREDICT, 0,   0,   0},
    '{STEP_REG,  REG_CLIP_MIN, 32767,  1'b0, 0, 0,   0,   0},
    '{STEP_REG,  REG_CLIP_MAX, -32768, 1'b0, 0, 0,   0,   0},
    '{STEP_CELL, 0,      'h0001, 1'b1, 0,       0,   0,   0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cell_valid = 1'b0;
  logic cell_ready;
  logic signed [XW-1:0] cell_x = '0;
  logic [MASK_W-1:0] cell_mask = '0;
  logic row_last = 1'b0;
  logic run_valid;
  logic run_ready = 1'b0;
  logic signed [XW-1:0] run_start;
  logic signed [XW-1:0] run_end;
  logic [COV_W-1:0] coverage;
  logic last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  scanline_coverage_span_resolver #(.X_BITS(XW)) dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic q_mode;
  int win_lo, win_hi;
  logic [SUB_ROWS-1:0] par;
  int held_x, held_cell, held_span;
  bit held_valid, row_halted;

  run_t step_runs[$];
  run_t runs_owed[$];
  int fault_count = 0;
  int cells_sent = 0;
  int runs_seen = 0;
  int regs_written = 0;
  bit send_eager = 1'b0;
  bit take_eager = 1'b0;

  function automatic void clear_row();
    par = '0;
    held_x = 0;
    held_cell = 0;
    held_span = 0;
    held_valid = 1'b0;
    row_halted = 1'b0;
  endfunction

  function automatic void add_run(int a, int b, int cov);
    run_t r;
    if (cov == 0 || a >= b) return;
    r.start_x = a[XW-1:0];
    r.stop_x = b[XW-1:0];
    r.cov = cov[COV_W-1:0];
    r.is_last = 1'b0;
    step_runs.push_back(r);
  endfunction

  function automatic void add_pixel_run(int x, int cov);
    if (x >= win_lo && x < win_hi) add_run(x, x + 1, cov);
  endfunction

  function automatic void add_gap_run(int x1);
    int x, e;
    x = held_x;
    e = x1;
    if (x >= win_lo) x++;
    if (x1 <= x || x1 <= win_lo) return;
    if (x < win_lo) x = win_lo;
    if (e > win_hi) e = win_hi;
    add_run(x, e, held_span);
  endfunction

  // pixel coverage from parity and toggles (low quality: old parity[0]); leaves toggled parity
  function automatic int toggle_cell(logic [MASK_W-1:0] m);
    int cov;
    logic d;
    cov = 0;
    if (!q_mode) begin
      cov = par[0];
      par[0] = par[0] ^ m[0];
      return cov;
    end
    for (int r = 0; r < SUB_ROWS; r++) begin
      d = par[r];
      if (d) cov += W_EDGE;
      for (int c = 0; c < SUB_COLS; c++) begin
        if (m[SUB_COLS*r+c]) d = ~d;
        if (d) cov += (c == SUB_COLS - 1) ? W_EDGE : W_MID;
      end
      par[r] = d;
    end
    return cov;
  endfunction

  function automatic int gap_coverage();
    if (!q_mode) return par[0];
    return SPAN_W * $countones(par);
  endfunction

  function automatic void resolve_cell(int x, logic [MASK_W-1:0] m, bit rl);
    int cc, sc;
    step_runs.delete();
    if (!row_halted) begin
      if (x >= win_hi) begin
        if (held_valid) begin
          add_pixel_run(held_x, held_cell);
          add_gap_run(x);
        end
        held_valid = 1'b0;
        row_halted = 1'b1;
      end else begin
        cc = toggle_cell(m);
        sc = gap_coverage();
        if (held_valid) begin
          add_pixel_run(held_x, held_cell);
          add_gap_run(x);
          if (rl) add_pixel_run(x, cc);
        end
        held_x = x;
        held_cell = cc;
        held_span = sc;
        held_valid = 1'b1;
      end
    end
    if (rl) clear_row();
    if (step_runs.size() > 0) step_runs[step_runs.size()-1].is_last = 1'b1;
  endfunction

  function automatic int clamp_x(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int draw_wait(bit eager);
    return eager ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic void note_fault(string why, run_t got, run_t want);
    fault_count++;
    if (fault_count <= MAX_SHOWN) begin
      $display("%0t %0s: got start=%0d end=%0d cov=%0d last=%0b",
               $time, why, got.start_x, got.stop_x, got.cov, got.is_last);
      $display("  expected start=%0d end=%0d cov=%0d last=%0b",
               want.start_x, want.stop_x, want.cov, want.is_last);
    end
  endfunction

  task automatic send_cell(int x, logic [MASK_W-1:0] m, bit rl, int n_fix, run_t fix);
    int gap;
    gap = draw_wait(send_eager);
    @(negedge clk);
    if (gap > 0) begin
      cell_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cell_valid <= 1'b1;
    cell_x <= x[XW-1:0];
    cell_mask <= m;
    row_last <= rl;
    do @(posedge clk); while (!cell_ready);
    cells_sent++;
    resolve_cell(x, m, rl);
    if (n_fix == PREDICT) begin
      foreach (step_runs[i]) runs_owed.push_back(step_runs[i]);
    end else if (n_fix > 0) begin
      runs_owed.push_back(fix);
    end
  endtask

  task automatic settle();
    int k;
    @(negedge clk) cell_valid <= 1'b0;
    for (k = 0; k < 5000 && runs_owed.size() > 0; k++) @(posedge clk);
    while (runs_owed.size() > 0) note_fault("run never arrived", '0, runs_owed.pop_front());
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, int val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    regs_written++;
    case (idx)
      REG_QUALITY:  q_mode = val[0];
      REG_CLIP_MIN: win_lo = $signed(val[XW-1:0]);
      REG_CLIP_MAX: win_hi = $signed(val[XW-1:0]);
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin : take_runs
    run_t got;
    int hold;
    forever begin
      hold = draw_wait(take_eager);
      if (hold > 0) begin
        @(negedge clk) run_ready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk) run_ready <= 1'b1;
      do @(posedge clk); while (!run_valid);
      got = '{run_start, run_end, coverage, last};
      runs_seen++;
      if (runs_owed.size() == 0) begin
        note_fault("run with nothing owed", got, '0);
      end else if (got.start_x !== runs_owed[0].start_x || got.stop_x !== runs_owed[0].stop_x ||
                   got.cov !== runs_owed[0].cov || got.is_last !== runs_owed[0].is_last) begin
        note_fault("run mismatch", got, runs_owed.pop_front());
      end else begin
        void'(runs_owed.pop_front());
      end
    end
  end

  initial begin : stimulus
    run_t fix;
    int x, len, lo, hi, q, sent;
    q_mode = 1'b1;
    win_lo = 0;
    win_hi = 1024;
    clear_row();
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (PLAN[i]) begin
      if (PLAN[i].kind == STEP_REG) begin
        settle();
        write_reg(IDX_W'(PLAN[i].a), PLAN[i].b);
      end else begin
        fix = '{XW'(PLAN[i].fix_s), XW'(PLAN[i].fix_e), COV_W'(PLAN[i].fix_c), 1'b1};
        send_cell(PLAN[i].a, MASK_W'(PLAN[i].b), PLAN[i].rl, PLAN[i].n_fix, fix);
      end
    end

    for (int p = 0; p < 6; p++) begin
      settle();
      send_eager = (p == 3);
      take_eager = (p == 3 || p == 4);
      q = (p < 2) ? p : $urandom_range(0, 1);
      case ($urandom_range(0, 3))
        0: begin
          lo = int'($urandom_range(0, 64)) - 32;
          hi = lo + int'($urandom_range(16, 300));
        end
        1: begin
          lo = -32768;
          hi = 32767;
        end
        2: begin
          lo = int'($urandom_range(0, 65535)) - 32768;
          hi = int'($urandom_range(0, 65535)) - 32768;
        end
        default: begin
          lo = 0;
          hi = 1024;
        end
      endcase
      write_reg(REG_QUALITY, q);
      write_reg(REG_CLIP_MIN, lo);
      write_reg(REG_CLIP_MAX, hi);
      sent = 0;
      while (sent < 50) begin
        if ($urandom_range(0, 9) == 0) begin
          send_cell(int'($urandom_range(0, 65535)) - 32768, MASK_W'($urandom), 1'($urandom),
                    PREDICT, fix);
          sent++;
        end else begin
          len = $urandom_range(1, 6);
          x = clamp_x(win_lo - 6 + int'($urandom_range(0, 40)));
          for (int c = 0; c < len; c++) begin
            send_cell(x, MASK_W'($urandom), c == len - 1, PREDICT, fix);
            if ($urandom_range(0, 15) == 0) x = clamp_x(x - int'($urandom_range(1, 5)));
            else x = clamp_x(x + int'($urandom_range(0, 24)));
          end
          sent += len;
        end
      end
    end

    settle();
    repeat (24) @(posedge clk);
    $display("covered %0d cells and %0d runs over %0d register writes", cells_sent, runs_seen,
             regs_written);
    $display("both coverage modes, clip window extremes, stopped and single-cell rows");
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures", fault_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("timeout");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
